@@ rtl/rbd_pkg.sv @@
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared constants and types for the 2x2 RGBA box downsampler.
// ----------------------------------------------------------------------------
package rbd_pkg;

   // Largest supported source image
   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;

   // Fixed field widths
   localparam int DIM_W  = 13;                  // width/height register
   localparam int CHAN_W = 8;                   // one color channel
   localparam int PAIR_W = CHAN_W + 1;          // sum of two channels
   localparam int QUAD_W = CHAN_W + 2;          // sum of four channels
   localparam int NUM_CH = 4;

   // Position counters and line store geometry
   localparam int XPOS_W     = $clog2(MAX_WIDTH);
   localparam int YPOS_W     = $clog2(MAX_HEIGHT);
   localparam int LINE_DEPTH = MAX_WIDTH / 2;
   localparam int LINE_AW    = $clog2(LINE_DEPTH);
   localparam int LINE_W     = NUM_CH * PAIR_W;

   // Register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 1'b1;

   // Reset value of the dimension registers
   localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(4096);

   // Packed channel groups: index 0 red, 1 green, 2 blue, 3 alpha
   typedef logic [NUM_CH-1:0][CHAN_W-1:0] pixel_type;
   typedef logic [NUM_CH-1:0][PAIR_W-1:0] pair_sums_type;

endpackage

@@ rtl/rbd_ram.sv @@
// ----------------------------------------------------------------------------
// rbd_ram
// Simple dual-port synchronous RAM, one write and one read port, registered
// read data that updates only on a read enable.
// ----------------------------------------------------------------------------
module rbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/rgba_box_downsample_2x2.sv @@
// ----------------------------------------------------------------------------
// rgba_box_downsample_2x2
// Builds the next mip level of an RGBA8 image with a 2x2 box filter. Pair
// sums of even rows sit in a line RAM; odd rows read them back and emit the
// floor of the four-pixel mean per channel.
// ----------------------------------------------------------------------------
//
//   channel   handshake            payload
//   req_      req_valid/req_ready  req_red_in, req_green_in, req_blue_in,
//                                  req_alpha_in
//   rsp_      rsp_valid/rsp_ready  rsp_red_out .. rsp_alpha_out, rsp_frame_done
//   csr_      csr_we               csr_index, csr_wdata
//
// One source pixel per cycle while req_ready is high. After its request is
// taken, a result passes through the line RAM read, then the output register.
// Reset is synchronous; no clearing pass is needed, since an odd row only
// reads entries the even row above wrote. While rsp_ready is low the block
// still takes requests until the RAM-read stage is also full.
//
module rgba_box_downsample_2x2 (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [rbd_pkg::CHAN_W-1:0]   req_red_in,
   input  logic [rbd_pkg::CHAN_W-1:0]   req_green_in,
   input  logic [rbd_pkg::CHAN_W-1:0]   req_blue_in,
   input  logic [rbd_pkg::CHAN_W-1:0]   req_alpha_in,

   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [rbd_pkg::CHAN_W-1:0]   rsp_red_out,
   output logic [rbd_pkg::CHAN_W-1:0]   rsp_green_out,
   output logic [rbd_pkg::CHAN_W-1:0]   rsp_blue_out,
   output logic [rbd_pkg::CHAN_W-1:0]   rsp_alpha_out,
   output logic                         rsp_frame_done,

   input  logic                         csr_we,
   input  logic [rbd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rbd_pkg::DIM_W-1:0]    csr_wdata
);

   // Configuration
   logic [rbd_pkg::DIM_W-1:0]  src_width_ff, src_height_ff;
   logic [rbd_pkg::DIM_W-1:0]  w_eff, h_eff;
   logic [rbd_pkg::DIM_W-2:0]  w_half, h_half;
   logic [rbd_pkg::DIM_W-2:0]  w_half_m1, h_half_m1;

   // Position and left pixel
   logic [rbd_pkg::XPOS_W-1:0] column_pos_ff, column_pos_in;
   logic [rbd_pkg::YPOS_W-1:0] row_pos_ff, row_pos_in;
   rbd_pkg::pixel_type         left_pixel_ff;
   rbd_pkg::pixel_type         pix;

   // Request decode
   logic                       req_fire;
   logic                       col_odd_ok, row_odd_ok;
   logic [rbd_pkg::LINE_AW-1:0] col;
   logic                       last_blk;
   logic                       wr_en, rd_en;
   rbd_pkg::pair_sums_type     pairs;
   logic [rbd_pkg::LINE_W-1:0] line_rd_data;
   rbd_pkg::pair_sums_type     above;

   // Read stage and output register
   logic                       s1_valid_ff;
   rbd_pkg::pair_sums_type     s1_pairs_ff;
   logic                       s1_last_ff;
   logic                       s1_move;
   logic                       rsp_valid_ff;
   rbd_pkg::pixel_type         rsp_pix_ff, rsp_pix_in;
   logic                       rsp_done_ff;

   // Clamp dimensions to [2, MAX]
   always_comb begin
      if (src_width_ff < rbd_pkg::DIM_W'(2)) begin
         w_eff = rbd_pkg::DIM_W'(2);
      end else if (src_width_ff > rbd_pkg::DIM_W'(rbd_pkg::MAX_WIDTH)) begin
         w_eff = rbd_pkg::DIM_W'(rbd_pkg::MAX_WIDTH);
      end else begin
         w_eff = src_width_ff;
      end
      if (src_height_ff < rbd_pkg::DIM_W'(2)) begin
         h_eff = rbd_pkg::DIM_W'(2);
      end else if (src_height_ff > rbd_pkg::DIM_W'(rbd_pkg::MAX_HEIGHT)) begin
         h_eff = rbd_pkg::DIM_W'(rbd_pkg::MAX_HEIGHT);
      end else begin
         h_eff = src_height_ff;
      end
   end

   assign w_half    = w_eff[rbd_pkg::DIM_W-1:1];
   assign h_half    = h_eff[rbd_pkg::DIM_W-1:1];
   assign w_half_m1 = w_half - 1'b1;
   assign h_half_m1 = h_half - 1'b1;

   // Handshake
   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_move;
   assign req_fire  = req_valid && req_ready;

   assign pix = {req_alpha_in, req_blue_in, req_green_in, req_red_in};

   // Odd column inside the even part of the width; odd row likewise
   assign col_odd_ok = column_pos_ff[0]
      && ({1'b0, column_pos_ff} < {w_half, 1'b0});
   assign row_odd_ok = row_pos_ff[0]
      && ({1'b0, row_pos_ff} < {h_half, 1'b0});
   assign col = column_pos_ff[rbd_pkg::XPOS_W-1:1];
   assign last_blk = ({1'b0, col} == w_half_m1)
      && ({1'b0, row_pos_ff[rbd_pkg::YPOS_W-1:1]} == h_half_m1);

   // Horizontal pair sums
   always_comb begin
      for (int c = 0; c < rbd_pkg::NUM_CH; c++) begin
         pairs[c] = rbd_pkg::PAIR_W'(left_pixel_ff[c]) + rbd_pkg::PAIR_W'(pix[c]);
      end
   end

   assign wr_en = req_fire && col_odd_ok && !row_pos_ff[0];
   assign rd_en = req_fire && col_odd_ok && row_odd_ok;

   // Line store of even-row pair sums
   rbd_ram #(
      .WIDTH (rbd_pkg::LINE_W),
      .DEPTH (rbd_pkg::LINE_DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (col),
      .wr_data (pairs),
      .rd_en   (rd_en),
      .rd_addr (col),
      .rd_data (line_rd_data)
   );

   assign above = line_rd_data;

   // Position advance
   always_comb begin
      column_pos_in = column_pos_ff;
      row_pos_in    = row_pos_ff;
      if (req_fire) begin
         if (({1'b0, column_pos_ff} + 1'b1) >= w_eff) begin
            column_pos_in = '0;
            if (({1'b0, row_pos_ff} + 1'b1) >= h_eff) begin
               row_pos_in = '0;
            end else begin
               row_pos_in = row_pos_ff + 1'b1;
            end
         end else begin
            column_pos_in = column_pos_ff + 1'b1;
         end
      end
   end

   // Configuration and position registers
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= rbd_pkg::DIM_RESET;
         src_height_ff <= rbd_pkg::DIM_RESET;
         column_pos_ff <= '0;
         row_pos_ff    <= '0;
         left_pixel_ff <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               rbd_pkg::CSR_SRC_WIDTH:  src_width_ff  <= csr_wdata;
               rbd_pkg::CSR_SRC_HEIGHT: src_height_ff <= csr_wdata;
               default: ;
            endcase
            column_pos_ff <= '0;
            row_pos_ff    <= '0;
         end else begin
            column_pos_ff <= column_pos_in;
            row_pos_ff    <= row_pos_in;
         end
         if (req_fire && !column_pos_ff[0]) begin
            left_pixel_ff <= pix;
         end
      end
   end

   // Vertical sum and divide by four
   always_comb begin
      logic [rbd_pkg::QUAD_W-1:0] quad;
      for (int c = 0; c < rbd_pkg::NUM_CH; c++) begin
         quad = rbd_pkg::QUAD_W'(above[c]) + rbd_pkg::QUAD_W'(s1_pairs_ff[c]);
         rsp_pix_in[c] = quad[rbd_pkg::QUAD_W-1:2];
      end
   end

   // Read stage and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rd_en) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         s1_pairs_ff <= pairs;
         s1_last_ff  <= last_blk;
      end
      if (s1_move) begin
         rsp_pix_ff  <= rsp_pix_in;
         rsp_done_ff <= s1_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red_out    = rsp_pix_ff[0];
   assign rsp_green_out  = rsp_pix_ff[1];
   assign rsp_blue_out   = rsp_pix_ff[2];
   assign rsp_alpha_out  = rsp_pix_ff[3];
   assign rsp_frame_done = rsp_done_ff;

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: 2x2 RGBA box downsampler
// Streams source pixels in raster order through the block under a range of
// image sizes. A scoreboard keeps its own line of pair sums and predicts each
// output pixel and its frame-end flag, and checks every output pixel against
// the oldest prediction. Both sides of the stream idle at random.
// ----------------------------------------------------------------------------
module testbench;

   localparam int unsigned CYCLE_LIMIT     = 1_000_000;
   localparam int unsigned SETTLE_CYCLES   = 8;
   localparam int unsigned HOLD_OFF_CYCLES = 300;
   localparam int unsigned RANDOM_ITEMS    = 350;

   // one predicted output pixel
   typedef struct packed {
      rbd_pkg::pixel_type rgba;
      logic               frame_end;
   } mip_texel_type;

   typedef enum {RX_ALWAYS, RX_MOSTLY, RX_ALTERNATE, RX_SPARSE} rx_mode_type;

   // Predicts the next mip level and checks the block's output pixels
   class mip_scoreboard;
      rbd_pkg::pair_sums_type    pair_line [rbd_pkg::LINE_DEPTH];
      rbd_pkg::pixel_type        left_px;
      int unsigned               col, row;
      logic [rbd_pkg::DIM_W-1:0] width_reg, height_reg;
      mip_texel_type             expected_mip_q [$];
      int unsigned      errors, sources, results, frame_ends, reg_writes, widest;

      function new();
         foreach (pair_line[i]) pair_line[i] = '0;
         left_px    = '0;
         col        = 0;
         row        = 0;
         width_reg  = rbd_pkg::DIM_RESET;
         height_reg = rbd_pkg::DIM_RESET;
         errors     = 0;
         sources    = 0;
         results    = 0;
         frame_ends = 0;
         reg_writes = 0;
         widest     = rbd_pkg::MAX_WIDTH;
      endfunction

      // sizes outside [2, max] are clamped
      function int unsigned eff_dim(logic [rbd_pkg::DIM_W-1:0] v, int unsigned maxv);
         if (v < 2) return 2;
         if (v > maxv) return maxv;
         return v;
      endfunction

      function int unsigned frame_pixels();
         return eff_dim(width_reg, rbd_pkg::MAX_WIDTH)
              * eff_dim(height_reg, rbd_pkg::MAX_HEIGHT);
      endfunction

      function int unsigned pending();
         return expected_mip_q.size();
      endfunction

      function void report(string msg);
         errors++;
         $display("%s", msg);
      endfunction

      // a size write restarts the frame; line contents stay
      function void write_reg(logic [rbd_pkg::CSR_IDX_W-1:0] idx,
                              logic [rbd_pkg::DIM_W-1:0] data);
         int unsigned w;
         if (idx == rbd_pkg::CSR_SRC_WIDTH) width_reg = data;
         else height_reg = data;
         col = 0;
         row = 0;
         reg_writes++;
         w = eff_dim(width_reg, rbd_pkg::MAX_WIDTH);
         if (w > widest) widest = w;
      endfunction

      function void note_source_pixel(rbd_pkg::pixel_type px);
         int unsigned                w, h, pair_col;
         int                         c;
         rbd_pkg::pair_sums_type     pairs;
         logic [rbd_pkg::QUAD_W-1:0] quad;
         mip_texel_type              texel;
         w = eff_dim(width_reg, rbd_pkg::MAX_WIDTH);
         h = eff_dim(height_reg, rbd_pkg::MAX_HEIGHT);
         sources++;
         // even column: hold it; odd column inside the even width: pair sum
         if (col % 2 == 0) begin
            left_px = px;
         end else if (col < 2 * (w / 2)) begin
            pair_col = col / 2;
            for (c = 0; c < rbd_pkg::NUM_CH; c++)
               pairs[c] = rbd_pkg::PAIR_W'(left_px[c]) + rbd_pkg::PAIR_W'(px[c]);
            if (row % 2 == 0) begin
               pair_line[pair_col] = pairs;
            end else if (row < 2 * (h / 2)) begin
               for (c = 0; c < rbd_pkg::NUM_CH; c++) begin
                  quad = rbd_pkg::QUAD_W'(pair_line[pair_col][c])
                       + rbd_pkg::QUAD_W'(pairs[c]);
                  texel.rgba[c] = quad[rbd_pkg::QUAD_W-1:2];
               end
               texel.frame_end = (pair_col == w / 2 - 1) && (row / 2 == h / 2 - 1);
               expected_mip_q = {expected_mip_q, texel};
            end
         end
         // raster advance, wrap at end of image
         if (col + 1 >= w) begin
            col = 0;
            row = (row + 1 >= h) ? 0 : row + 1;
         end else begin
            col++;
         end
      endfunction

      function void check_mip_pixel(mip_texel_type got);
         mip_texel_type want;
         string         names [rbd_pkg::NUM_CH];
         int            c;
         names = '{"red", "green", "blue", "alpha"};
         results++;
         if (expected_mip_q.size() == 0) begin
            report($sformatf("%0t: output pixel %h with none expected", $time, got));
            return;
         end
         want = expected_mip_q.pop_front();
         for (c = 0; c < rbd_pkg::NUM_CH; c++)
            if (got.rgba[c] !== want.rgba[c])
               report($sformatf("%0t: %s mismatch, expected %0d, got %0d",
                                $time, names[c], want.rgba[c], got.rgba[c]));
         if (got.frame_end !== want.frame_end)
            report($sformatf("%0t: frame_done mismatch, expected %0b, got %0b",
                             $time, want.frame_end, got.frame_end));
         if (want.frame_end) frame_ends++;
      endfunction
   endclass

   logic                          clock, reset;
   logic                          req_valid, req_ready;
   logic [rbd_pkg::CHAN_W-1:0]    req_red_in, req_green_in, req_blue_in, req_alpha_in;
   logic                          rsp_valid, rsp_ready;
   logic [rbd_pkg::CHAN_W-1:0]    rsp_red_out, rsp_green_out, rsp_blue_out;
   logic [rbd_pkg::CHAN_W-1:0]    rsp_alpha_out;
   logic                          rsp_frame_done;
   logic                          csr_we;
   logic [rbd_pkg::CSR_IDX_W-1:0] csr_index;
   logic [rbd_pkg::DIM_W-1:0]     csr_wdata;

   mip_scoreboard sb;
   int unsigned   burst_left;
   bit            steady;
   bit            hold_off_armed;
   int unsigned   hold_offs;
   int unsigned   cycle_count;

   rgba_box_downsample_2x2 DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_red_in     (req_red_in),
      .req_green_in   (req_green_in),
      .req_blue_in    (req_blue_in),
      .req_alpha_in   (req_alpha_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_red_out    (rsp_red_out),
      .rsp_green_out  (rsp_green_out),
      .rsp_blue_out   (rsp_blue_out),
      .rsp_alpha_out  (rsp_alpha_out),
      .rsp_frame_done (rsp_frame_done),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("TEST FAILED");
         $finish;
      end
   end

   // sample handshakes and register writes at the rising edge
   always @(posedge clock) begin : monitor
      mip_texel_type got;
      if (!reset) begin
         if (csr_we) sb.write_reg(csr_index, csr_wdata);
         if (req_valid && req_ready)
            sb.note_source_pixel({req_alpha_in, req_blue_in, req_green_in, req_red_in});
         if (rsp_valid && rsp_ready) begin
            got.rgba      = {rsp_alpha_out, rsp_blue_out, rsp_green_out, rsp_red_out};
            got.frame_end = rsp_frame_done;
            sb.check_mip_pixel(got);
         end
      end
   end

   // receiver: random stall modes, plus one long hold-off on request
   initial begin : receiver
      rx_mode_type mode;
      int unsigned span;
      rsp_ready <= 1'b0;
      mode = RX_ALWAYS;
      span = 0;
      forever begin
         @(negedge clock);
         if (hold_off_armed) begin
            hold_off_armed = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_offs++;
         end else begin
            if (span == 0) begin
               mode = rx_mode_type'($urandom_range(0, 3));
               span = $urandom_range(16, 96);
            end
            span--;
            case (mode)
               RX_ALWAYS:    rsp_ready <= 1'b1;
               RX_MOSTLY:    rsp_ready <= ($urandom_range(0, 3) != 0);
               RX_ALTERNATE: rsp_ready <= ~rsp_ready;
               default:      rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   function automatic rbd_pkg::pixel_type rgba(input int r, g, b, a);
      return {rbd_pkg::CHAN_W'(a), rbd_pkg::CHAN_W'(b),
              rbd_pkg::CHAN_W'(g), rbd_pkg::CHAN_W'(r)};
   endfunction

   // channels lean toward the extremes now and then
   function automatic rbd_pkg::pixel_type random_pixel();
      rbd_pkg::pixel_type px;
      int                 c;
      for (c = 0; c < rbd_pkg::NUM_CH; c++)
         case ($urandom_range(0, 7))
            0:       px[c] = '0;
            1:       px[c] = '1;
            default: px[c] = rbd_pkg::CHAN_W'($urandom_range(0, 255));
         endcase
      return px;
   endfunction

   // mostly small sizes, sometimes clamped or very large ones
   function automatic logic [rbd_pkg::DIM_W-1:0] pick_dim(input int unsigned common_max);
      case ($urandom_range(0, 19))
         0:       return rbd_pkg::DIM_W'($urandom_range(0, 1));
         1:       return rbd_pkg::DIM_W'(4096 + $urandom_range(0, 1));
         2:       return '1;
         3:       return rbd_pkg::DIM_W'($urandom_range(0, 8191));
         4, 5:    return rbd_pkg::DIM_W'($urandom_range(11, 64));
         default: return rbd_pkg::DIM_W'($urandom_range(2, common_max));
      endcase
   endfunction

   // holds the request until accepted; returns on the next falling edge
   task automatic send_pixel(input rbd_pkg::pixel_type px);
      req_valid    <= 1'b1;
      req_red_in   <= px[0];
      req_green_in <= px[1];
      req_blue_in  <= px[2];
      req_alpha_in <= px[3];
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      @(negedge clock);
   endtask

   // bursts of random length separated by random gaps
   task automatic pace();
      int unsigned gap;
      if (steady) return;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(1, 6);
      req_valid <= 1'b0;
      repeat (gap) @(negedge clock);
   endtask

   task automatic wait_drained(input int unsigned extra);
      req_valid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
      repeat (extra) @(negedge clock);
   endtask

   task automatic write_reg(input logic [rbd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [rbd_pkg::DIM_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // sizes change only once the block has gone quiet
   task automatic configure(input bit write_w, write_h,
                            input logic [rbd_pkg::DIM_W-1:0] w, h);
      wait_drained(SETTLE_CYCLES);
      if (write_w) write_reg(rbd_pkg::CSR_SRC_WIDTH, w);
      if (write_h) write_reg(rbd_pkg::CSR_SRC_HEIGHT, h);
   endtask

   task automatic stream(input int unsigned count);
      repeat (count) begin
         pace();
         if ($urandom_range(0, 99) == 0) wait_drained(0);
         send_pixel(random_pixel());
      end
   endtask

   initial begin : stimulus
      rbd_pkg::pixel_type corner [12];
      int unsigned        fp, count, random_sent;
      sb = new();
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_red_in   <= '0;
      req_green_in <= '0;
      req_blue_in  <= '0;
      req_alpha_in <= '0;
      csr_we       <= 1'b0;
      csr_index    <= rbd_pkg::CSR_SRC_WIDTH;
      csr_wdata    <= '0;
      burst_left     = 0;
      steady         = 1'b1;
      hold_off_armed = 1'b0;
      hold_offs      = 0;
      cycle_count    = 0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // reset sizes: part of a row, then a size write restarts the frame
      stream(4);

      // 2x2 after clamping: saturated, zero, and truncating blocks
      configure(1'b1, 1'b1, rbd_pkg::DIM_W'(0), rbd_pkg::DIM_W'(1));
      for (int i = 0; i < 4; i++) corner[i] = rgba(255, 255, 255, 255);
      for (int i = 4; i < 8; i++) corner[i] = rgba(0, 0, 0, 0);
      corner[8]  = rgba(255, 1, 0, 128);
      corner[9]  = rgba(255, 1, 255, 128);
      corner[10] = rgba(255, 1, 0, 128);
      corner[11] = rgba(254, 0, 255, 127);
      foreach (corner[i]) send_pixel(corner[i]);

      // odd last column and odd last row are dropped
      configure(1'b1, 1'b1, rbd_pkg::DIM_W'(3), rbd_pkg::DIM_W'(3));
      stream(9);

      // clamped widest line in part, a wide full frame, then a tall partial frame
      steady = 1'b0;
      configure(1'b1, 1'b1, '1, rbd_pkg::DIM_W'(2));
      stream(64);
      configure(1'b1, 1'b1, rbd_pkg::DIM_W'(320), rbd_pkg::DIM_W'(2));
      stream(640);
      configure(1'b1, 1'b1, rbd_pkg::DIM_W'(2), rbd_pkg::DIM_W'(rbd_pkg::MAX_HEIGHT));
      stream(300);

      // receiver holds off while requests keep coming
      configure(1'b1, 1'b1, rbd_pkg::DIM_W'(2), rbd_pkg::DIM_W'(6));
      steady         = 1'b1;
      hold_off_armed = 1'b1;
      stream(120);

      // random sizes and content
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 3))
            0:       configure(1'b1, 1'b0, pick_dim(10), '0);
            1:       configure(1'b0, 1'b1, '0, pick_dim(8));
            default: configure(1'b1, 1'b1, pick_dim(10), pick_dim(8));
         endcase
         steady = ($urandom_range(0, 3) == 0);
         fp = sb.frame_pixels();
         if (fp <= 600) count = fp * $urandom_range(1, 2) + $urandom_range(0, fp - 1);
         else count = $urandom_range(16, 300);
         if (count > RANDOM_ITEMS - random_sent) count = RANDOM_ITEMS - random_sent;
         stream(count);
         random_sent += count;
      end

      wait_drained(2 * SETTLE_CYCLES);
      $display("covered %0d source pixels, %0d output pixels, %0d frame ends",
               sb.sources, sb.results, sb.frame_ends);
      $display("%0d size writes, widest line %0d pixels, %0d long receiver hold-offs",
               sb.reg_writes, sb.widest, hold_offs);
      if (sb.errors == 0 && sb.pending() == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule

@@ rgba_box_downsample_2x2.f @@
rtl/rbd_pkg.sv
rtl/rbd_ram.sv
rtl/rgba_box_downsample_2x2.sv
bench/testbench.sv
